// File: hdl/uer_pkg.sv
// Shared types, constants and helpers for the ultrasonic echo ranger.
package uer_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_TRIG   = 4'b0010,
    PH_LISTEN = 4'b0100,
    PH_GAP    = 4'b1000
  } phase_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_HAND   = 2'd2;

  localparam logic [1:0] CFG_TRIGGER_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ECHO_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_HAND_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_REPEAT_GAP     = 2'd3;

  localparam int CFG_DATA_W = 20;

  localparam logic [9:0]  RST_TRIGGER_WIDTH  = 10'd10;
  localparam logic [15:0] RST_ECHO_TIMEOUT   = 16'd30000;
  localparam logic [9:0]  RST_HAND_THRESHOLD = 10'd3;
  localparam logic [19:0] RST_REPEAT_GAP     = 20'd200000;

  localparam logic [9:0]  TIMEOUT_CM = 10'd999;
  localparam logic [9:0]  MAX_CM     = 10'd1023;
  localparam logic [15:0] PULSE_MAX  = 16'hFFFF;

  // Division by 58 as a multiply by ceil(2^22 / 58) and a shift; exact for 16-bit pulses.
  localparam int          CM_DIVISOR = 58;
  localparam int          RECIP_SHIFT = 22;
  localparam logic [16:0] RECIP_58 = 17'((2 ** RECIP_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR);

  typedef struct packed {
    logic [9:0]  trigger_width_us;
    logic [15:0] echo_timeout_us;
    logic [9:0]  hand_threshold_cm;
    logic [19:0] repeat_gap_us;
  } cfg_t;

  typedef struct packed {
    logic       trigger_level;
    logic       busy_res;
    logic       result_valid;
    logic [9:0] distance_cm;
    logic       timed_out;
    logic       hand_detected;
  } res_t;

  function automatic logic [9:0] pulse_to_cm(input logic [15:0] pulse);
    logic [32:0] prod;
    logic [10:0] quot;
    prod = 33'(pulse) * 33'(RECIP_58);
    quot = prod[32:RECIP_SHIFT];
    pulse_to_cm = (quot > 11'(MAX_CM)) ? MAX_CM : quot[9:0];
  endfunction

endpackage

// File: hdl/uer_core.sv
// Measurement sequencer: phase state, timers and per-tick result.
module uer_core #(
  parameter int TIMER_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        opcode,
  input  logic              level,
  input  uer_pkg::cfg_t     cfg,
  output uer_pkg::res_t     res
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam int GW = (TIMER_BITS > 20) ? TIMER_BITS : 20;

  uer_pkg::phase_t       phase, phase_next;
  logic [TIMER_BITS-1:0] phase_timer, phase_timer_next;
  logic [15:0]           pulse_timer, pulse_timer_next;
  logic                  echo_seen_high, echo_seen_high_next;
  logic                  echo_previous;
  logic                  hand_mode, hand_mode_next;

  logic [GW-1:0]         gap_ext, tmax_ext, gap_clamped;
  logic                  gap_reached;
  logic [9:0]            dist_meas;
  logic                  done;

  assign gap_ext     = GW'(cfg.repeat_gap_us);
  assign tmax_ext    = GW'(TMAX);
  assign gap_clamped = (gap_ext > tmax_ext) ? tmax_ext : gap_ext;
  assign gap_reached = GW'(phase_timer) >= gap_clamped;
  assign dist_meas   = uer_pkg::pulse_to_cm(pulse_timer);

  always_comb begin
    phase_next          = phase;
    phase_timer_next    = phase_timer;
    pulse_timer_next    = pulse_timer;
    echo_seen_high_next = echo_seen_high;
    hand_mode_next      = hand_mode;
    done                = 1'b0;
    res                 = '0;

    case (phase)
      uer_pkg::PH_IDLE: begin
        if (opcode == uer_pkg::OP_SINGLE || opcode == uer_pkg::OP_HAND) begin
          hand_mode_next      = (opcode == uer_pkg::OP_HAND);
          phase_next          = uer_pkg::PH_TRIG;
          phase_timer_next    = TIMER_BITS'(1);
          pulse_timer_next    = '0;
          echo_seen_high_next = 1'b0;
          res.trigger_level   = 1'b1;
        end
      end
      uer_pkg::PH_GAP: begin
        if (gap_reached) begin
          phase_next          = uer_pkg::PH_TRIG;
          phase_timer_next    = TIMER_BITS'(1);
          pulse_timer_next    = '0;
          echo_seen_high_next = 1'b0;
          res.trigger_level   = 1'b1;
        end else begin
          phase_timer_next = (phase_timer == TMAX) ? TMAX : phase_timer + TIMER_BITS'(1);
        end
      end
      uer_pkg::PH_TRIG: begin
        if (phase_timer < TIMER_BITS'(cfg.trigger_width_us)) begin
          phase_timer_next  = (phase_timer == TMAX) ? TMAX : phase_timer + TIMER_BITS'(1);
          res.trigger_level = 1'b1;
        end else begin
          phase_next       = uer_pkg::PH_LISTEN;
          phase_timer_next = '0;
        end
      end
      default: ;
    endcase

    // The first listen tick is the same tick in which the trigger drops.
    if (phase_next == uer_pkg::PH_LISTEN) begin
      if (level && !echo_previous) begin
        echo_seen_high_next = 1'b1;
        pulse_timer_next    = 16'd1;
      end else if (level && echo_seen_high_next) begin
        if (pulse_timer_next != uer_pkg::PULSE_MAX) begin
          pulse_timer_next = pulse_timer_next + 16'd1;
        end
      end else if (!level && echo_previous && echo_seen_high_next) begin
        res.distance_cm = dist_meas;
        done            = 1'b1;
      end
      if (!done && phase_timer_next >= TIMER_BITS'(cfg.echo_timeout_us)) begin
        res.distance_cm = uer_pkg::TIMEOUT_CM;
        res.timed_out   = 1'b1;
        done            = 1'b1;
      end
      if (done) begin
        res.result_valid    = 1'b1;
        echo_seen_high_next = 1'b0;
        pulse_timer_next    = '0;
        phase_timer_next    = '0;
        if (hand_mode_next) begin
          if (res.distance_cm <= cfg.hand_threshold_cm) begin
            res.hand_detected = 1'b1;
            hand_mode_next    = 1'b0;
            phase_next        = uer_pkg::PH_IDLE;
          end else begin
            phase_next = uer_pkg::PH_GAP;
          end
        end else begin
          phase_next = uer_pkg::PH_IDLE;
        end
      end else begin
        phase_timer_next = (phase_timer_next == TMAX) ? TMAX
                                                      : phase_timer_next + TIMER_BITS'(1);
      end
    end

    res.busy_res = (phase_next != uer_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= uer_pkg::PH_IDLE;
      phase_timer    <= '0;
      pulse_timer    <= '0;
      echo_seen_high <= 1'b0;
      echo_previous  <= 1'b0;
      hand_mode      <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      phase_timer    <= phase_timer_next;
      pulse_timer    <= pulse_timer_next;
      echo_seen_high <= echo_seen_high_next;
      echo_previous  <= level;
      hand_mode      <= hand_mode_next;
    end
  end

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: handshakes, configuration and result register.
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_stall    opcode, echo_level
//   output    out         out_valid / out_stall  trigger_level, busy_res, result_valid,
//                                                distance_cm, timed_out, hand_detected
//   config    in          cfg_write              cfg_index, cfg_data
//
// One item per cycle while out_stall does not hold the flow; an item passes through the
// input register and then the result register, from which its result is shown.
// Every input item yields exactly one result item.
// Reset clears the phase to idle, all timers, and loads the register defaults.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall in the same cycle.
module ultrasonic_echo_ranger #(
  parameter int TIMER_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic        echo_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        trigger_level,
  output logic        busy_res,
  output logic        result_valid,
  output logic [9:0]  distance_cm,
  output logic        timed_out,
  output logic        hand_detected,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  uer_pkg::cfg_t cfg;
  uer_pkg::res_t core_res;
  uer_pkg::res_t res;

  logic       s1_valid;
  logic [1:0] s1_opcode;
  logic       s1_level;
  logic       advance;
  logic       s1_go;

  assign advance  = !out_valid || !out_stall;
  assign s1_go    = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width_us  <= uer_pkg::RST_TRIGGER_WIDTH;
      cfg.echo_timeout_us   <= uer_pkg::RST_ECHO_TIMEOUT;
      cfg.hand_threshold_cm <= uer_pkg::RST_HAND_THRESHOLD;
      cfg.repeat_gap_us     <= uer_pkg::RST_REPEAT_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        uer_pkg::CFG_TRIGGER_WIDTH:  cfg.trigger_width_us  <= cfg_data[9:0];
        uer_pkg::CFG_ECHO_TIMEOUT:   cfg.echo_timeout_us   <= cfg_data[15:0];
        uer_pkg::CFG_HAND_THRESHOLD: cfg.hand_threshold_cm <= cfg_data[9:0];
        uer_pkg::CFG_REPEAT_GAP:     cfg.repeat_gap_us     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_opcode <= opcode;
      s1_level  <= echo_level;
    end
  end

  uer_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go),
    .opcode (s1_opcode),
    .level  (s1_level),
    .cfg    (cfg),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res <= core_res;
    end
  end

  assign trigger_level = res.trigger_level;
  assign busy_res      = res.busy_res;
  assign result_valid  = res.result_valid;
  assign distance_cm   = res.distance_cm;
  assign timed_out     = res.timed_out;
  assign hand_detected = res.hand_detected;

endmodule

// File: hdl/uer_check.sv
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
module uer_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       trigger_level,
  input logic       busy_res,
  input logic       result_valid,
  input logic [9:0] distance_cm,
  input logic       timed_out,
  input logic       hand_detected
);

  // A stalled result must not change.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_cm) && $stable(result_valid))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (timed_out || hand_detected) |-> result_valid)
    else $error("timeout or hand flag without a finished measurement");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> distance_cm == uer_pkg::TIMEOUT_CM)
    else $error("timeout without the timeout distance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_valid |-> distance_cm == 10'd0)
    else $error("distance shown without a finished measurement");

  // Hand detection ends hand-wait mode, and a trigger tick is always a busy tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (hand_detected || trigger_level) |-> (busy_res == !hand_detected))
    else $error("busy flag inconsistent with hand detection or trigger");

endmodule

bind ultrasonic_echo_ranger uer_check u_uer_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .trigger_level (trigger_level),
  .busy_res      (busy_res),
  .result_valid  (result_valid),
  .distance_cm   (distance_cm),
  .timed_out     (timed_out),
  .hand_detected (hand_detected)
);
